@@ rtl/gdmm_pkg.sv @@
// Shared codes and widths for the grid domino matching block.
package gdmm_pkg;
  localparam int CNT_W = 10;
  localparam int CNT_MAX = 1023;
  localparam logic FUNC_BLOCK = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;
  localparam logic [1:0] DIR_UP = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;
endpackage

@@ rtl/grid_domino_max_matching.sv @@
// Top level: domino count of a square grid by augmenting-path bipartite matching.
// A blocked-cell beat is taken while busy stays low, one beat per cycle.
// A solve beat holds busy while the matcher walks the grid, search step by search step
// and level by level of each augmenting path, through the one-read-port cell memories.
// The count leaves as one out_valid beat; the receiver cannot stall it.
// After reset and after every solve a clear sweep over all 2**(2*clog2(MAX_SIDE)) addresses
// (1024 at the default) empties the blocked, partner and visited memories while busy is high.
module grid_domino_max_matching #(
  parameter int MAX_SIDE = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [5:0]                in_row,
  input  logic [5:0]                in_col,
  output logic                      out_valid,
  output logic [gdmm_pkg::CNT_W-1:0] out_pair_count,
  input  logic                      cfg_we,
  input  logic [5:0]                cfg_wdata
);
  import gdmm_pkg::*;

  localparam int RW = $clog2(MAX_SIDE);
  localparam int SW = RW + 1;
  localparam int IW = 2 * RW;
  localparam int DW = IW + 1;
  localparam int DEPTH = 1 << IW;
  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int CMPW = (SW > 7) ? SW : 7;
  localparam int CW = (IW > CNT_W) ? IW : CNT_W;

  localparam logic [3:0] ST_CLR = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_WRD = 4'd2;
  localparam logic [3:0] ST_WCHK = 4'd3;
  localparam logic [3:0] ST_STEP = 4'd4;
  localparam logic [3:0] ST_NCHK = 4'd5;
  localparam logic [3:0] ST_AUGA = 4'd6;
  localparam logic [3:0] ST_AUGB = 4'd7;
  localparam logic [3:0] ST_AUGLD = 4'd8;
  localparam logic [3:0] ST_POPLD = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  typedef struct packed {
    logic          valid;
    logic [IW-1:0] node;
  } partner_t;

  typedef struct packed {
    logic [IW-1:0] node;
    logic [2:0]    dir;
  } frame_t;

  // Cell memories; blocked, partner and visited are addressed by {row, col}, the stack by depth.
  logic     blk_mem [DEPTH];
  partner_t par_mem [DEPTH];
  logic [IW-1:0] vis_mem [DEPTH];
  frame_t   stk_mem [DEPTH];

  logic          blk_rd_r;
  partner_t      par_rd_r;
  logic [IW-1:0] vis_rd_r;
  frame_t        stk_rd_r;

  logic [3:0]    state_r;
  logic [IW-1:0] clr_addr_r;
  logic [5:0]    side_cfg_r;
  logic [RW-1:0] wr_r, wc_r;
  logic [IW-1:0] attempt_r;
  logic [IW-1:0] cnt_r;
  logic [IW-1:0] top_cell_r;
  logic [2:0]    top_dir_r;
  logic [DW-1:0] depth_r;
  logic [DW-1:0] lvl_r;
  logic [IW-1:0] v_r;
  logic [IW-1:0] aug_a_r, aug_b_r;
  logic          out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;

  function automatic logic [IW-1:0] move(input logic [IW-1:0] idx, input logic [1:0] d);
    logic [RW-1:0] r;
    logic [RW-1:0] c;
    r = idx[IW-1:RW];
    c = idx[RW-1:0];
    case (d)
      DIR_UP:    r = r - RW'(1);
      DIR_DOWN:  r = r + RW'(1);
      DIR_LEFT:  c = c - RW'(1);
      DIR_RIGHT: c = c + RW'(1);
      default:   r = r;
    endcase
    return {r, c};
  endfunction

  // Effective side: min(grid_side, MAX_SIDE).
  logic [SW-1:0] side;
  always_comb begin
    if (CMPW'(side_cfg_r) > CMPW'(MAX_SIDE)) side = SW'(MAX_SIDE);
    else side = SW'(side_cfg_r);
  end

  // Blocked-cell beat decode.
  logic          load_ok;
  logic [IW-1:0] load_addr;
  logic [6:0]    row_m1, col_m1;
  assign row_m1 = {1'b0, in_row} - 7'd1;
  assign col_m1 = {1'b0, in_col} - 7'd1;
  assign load_ok = (state_r == ST_IDLE) && start && (in_func == FUNC_BLOCK) &&
                   (in_row != 6'd0) && (in_col != 6'd0) &&
                   (CMPW'(in_row) <= CMPW'(side)) && (CMPW'(in_col) <= CMPW'(side));
  assign load_addr = {RW'(row_m1), RW'(col_m1)};

  // Neighbour of the top frame in its current direction.
  logic [RW-1:0] tr, tc;
  logic          nb_in;
  logic [IW-1:0] nb;
  assign tr = top_cell_r[IW-1:RW];
  assign tc = top_cell_r[RW-1:0];
  assign nb = move(top_cell_r, top_dir_r[1:0]);
  always_comb begin
    case (top_dir_r[1:0])
      DIR_UP:    nb_in = (tr != '0);
      DIR_DOWN:  nb_in = ({1'b0, tr} + SW'(1)) < side;
      DIR_LEFT:  nb_in = (tc != '0);
      DIR_RIGHT: nb_in = ({1'b0, tc} + SW'(1)) < side;
      default:   nb_in = 1'b0;
    endcase
  end

  // Grid walk advance.
  logic walk_last_c, walk_last_r;
  assign walk_last_c = ({1'b0, wc_r} + SW'(1)) >= side;
  assign walk_last_r = ({1'b0, wr_r} + SW'(1)) >= side;

  // Memory port control.
  logic [IW-1:0] rd_addr, stk_rd_addr;
  logic          clr;
  logic          blk_we, par_we, vis_we, stk_we;
  logic          blk_wd;
  logic [IW-1:0] blk_wa, par_wa, vis_wa, stk_wa;
  partner_t      par_wd;
  logic [IW-1:0] vis_wd;
  frame_t        stk_wd;

  assign clr = (state_r == ST_CLR);

  always_comb begin
    rd_addr = {wr_r, wc_r};
    if (state_r == ST_STEP) rd_addr = nb;
    stk_rd_addr = IW'(depth_r - DW'(2));
    if (state_r == ST_AUGB) stk_rd_addr = IW'(lvl_r - DW'(1));

    blk_we = clr || load_ok;
    blk_wa = clr ? clr_addr_r : load_addr;
    blk_wd = !clr;

    par_we = clr || (state_r == ST_AUGA) || (state_r == ST_AUGB);
    par_wa = clr_addr_r;
    par_wd = '0;
    if (state_r == ST_AUGA) begin
      par_wa = aug_a_r;
      par_wd = '{valid: 1'b1, node: aug_b_r};
    end else if (state_r == ST_AUGB) begin
      par_wa = aug_b_r;
      par_wd = '{valid: 1'b1, node: aug_a_r};
    end

    vis_we = clr || ((state_r == ST_NCHK) && !blk_rd_r && (vis_rd_r != attempt_r));
    vis_wa = clr ? clr_addr_r : v_r;
    vis_wd = clr ? '0 : attempt_r;

    stk_we = (state_r == ST_NCHK) && !blk_rd_r && (vis_rd_r != attempt_r) &&
             par_rd_r.valid && (depth_r < DW'(CELL_COUNT));
    stk_wa = IW'(depth_r - DW'(1));
    stk_wd = '{node: top_cell_r, dir: top_dir_r};
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    if (par_we) par_mem[par_wa] <= par_wd;
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    blk_rd_r <= blk_mem[rd_addr];
    par_rd_r <= par_mem[rd_addr];
    vis_rd_r <= vis_mem[rd_addr];
    stk_rd_r <= stk_mem[stk_rd_addr];
  end

  // Saturate the count to the port width.
  logic [CW-1:0] cnt_ext;
  assign cnt_ext = CW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      side_cfg_r  <= 6'd32;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) side_cfg_r <= cfg_wdata;
      case (state_r)
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + IW'(1);
          if (clr_addr_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start && (in_func == FUNC_SOLVE)) begin
            cnt_r     <= '0;
            attempt_r <= '0;
            wr_r      <= '0;
            wc_r      <= '0;
            state_r   <= (side == '0) ? ST_DONE : ST_WRD;
          end
        end
        ST_WRD: begin
          // Odd cells are never a search root: skip them here.
          if (wr_r[0] ^ wc_r[0]) begin
            if (!walk_last_c) wc_r <= wc_r + RW'(1);
            else if (!walk_last_r) begin
              wr_r <= wr_r + RW'(1);
              wc_r <= '0;
            end else state_r <= ST_DONE;
          end else state_r <= ST_WCHK;
        end
        ST_WCHK: begin
          if (!blk_rd_r && !par_rd_r.valid) begin
            attempt_r  <= attempt_r + IW'(1);
            top_cell_r <= {wr_r, wc_r};
            top_dir_r  <= 3'd0;
            depth_r    <= DW'(1);
            state_r    <= ST_STEP;
          end else if (!walk_last_c) begin
            wc_r    <= wc_r + RW'(1);
            state_r <= ST_WRD;
          end else if (!walk_last_r) begin
            wr_r    <= wr_r + RW'(1);
            wc_r    <= '0;
            state_r <= ST_WRD;
          end else state_r <= ST_DONE;
        end
        ST_STEP: begin
          if (top_dir_r[2]) begin
            if (depth_r == DW'(1)) begin
              // Root exhausted: attempt fails, advance the walk.
              if (!walk_last_c) begin
                wc_r    <= wc_r + RW'(1);
                state_r <= ST_WRD;
              end else if (!walk_last_r) begin
                wr_r    <= wr_r + RW'(1);
                wc_r    <= '0;
                state_r <= ST_WRD;
              end else state_r <= ST_DONE;
            end else state_r <= ST_POPLD;
          end else begin
            top_dir_r <= top_dir_r + 3'd1;
            v_r       <= nb;
            if (nb_in) state_r <= ST_NCHK;
          end
        end
        ST_NCHK: begin
          if (blk_rd_r || (vis_rd_r == attempt_r)) state_r <= ST_STEP;
          else if (!par_rd_r.valid) begin
            aug_a_r <= top_cell_r;
            aug_b_r <= v_r;
            lvl_r   <= depth_r - DW'(1);
            state_r <= ST_AUGA;
          end else begin
            if (depth_r < DW'(CELL_COUNT)) begin
              top_cell_r <= par_rd_r.node;
              top_dir_r  <= 3'd0;
              depth_r    <= depth_r + DW'(1);
            end
            state_r <= ST_STEP;
          end
        end
        ST_AUGA: state_r <= ST_AUGB;
        ST_AUGB: begin
          if (lvl_r == '0) begin
            cnt_r <= cnt_r + IW'(1);
            if (!walk_last_c) begin
              wc_r    <= wc_r + RW'(1);
              state_r <= ST_WRD;
            end else if (!walk_last_r) begin
              wr_r    <= wr_r + RW'(1);
              wc_r    <= '0;
              state_r <= ST_WRD;
            end else state_r <= ST_DONE;
          end else begin
            lvl_r   <= lvl_r - DW'(1);
            state_r <= ST_AUGLD;
          end
        end
        ST_AUGLD: begin
          // Rebuild the edge this level took: its direction was advanced past it.
          aug_a_r <= stk_rd_r.node;
          aug_b_r <= move(stk_rd_r.node, stk_rd_r.dir[1:0] - 2'd1);
          state_r <= ST_AUGA;
        end
        ST_POPLD: begin
          top_cell_r <= stk_rd_r.node;
          top_dir_r  <= stk_rd_r.dir;
          depth_r    <= depth_r - DW'(1);
          state_r    <= ST_STEP;
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          out_cnt_r   <= (cnt_ext > CW'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cnt_ext[CNT_W-1:0];
          clr_addr_r  <= '0;
          state_r     <= ST_CLR;
        end
        default: state_r <= ST_CLR;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pair_count = out_cnt_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe outside clear sweep");
  a_step_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (depth_r != '0)) else $error("search step on empty stack");
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_SOLVE)) |=> busy) else $error("solve not taken");
endmodule

@@ tb/tb_grid_domino_max_matching.sv @@
// Testbench for the grid domino matching block: directed table, then random load/solve phases.
module tb_grid_domino_max_matching;
  timeunit 1ns;
  timeprecision 1ps;
  import gdmm_pkg::*;

  localparam int SIDE_MAX = 32;
  localparam int NO_EXPECT = -1;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic      func;
    logic [5:0] row;
    logic [5:0] col;
    logic [5:0] side;
    int        expect_cnt;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_func;
  logic [5:0] in_row;
  logic [5:0] in_col;
  logic out_valid;
  logic [CNT_W-1:0] out_pair_count;
  logic cfg_we;
  logic [5:0] cfg_wdata;

  grid_domino_max_matching dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_row(in_row), .in_col(in_col),
    .out_valid(out_valid), .out_pair_count(out_pair_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Shadow copy of the block state.
  logic [5:0] shadow_side;
  bit blocked_cell [SIDE_MAX][SIDE_MAX];
  int partner_of [SIDE_MAX][SIDE_MAX];
  bit seen_cell [SIDE_MAX][SIDE_MAX];
  int active_side;

  logic [CNT_W-1:0] pending_counts[$];
  int mismatches;
  int sent_beats;

  // Grow an augmenting path from even cell (r,c); probe up, down, left, right.
  function automatic bit grow_path(int r, int c);
    int nr, nc, mate;
    for (int d = 0; d < 4; d++) begin
      nr = r + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
      nc = c + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
      if (nr < 0 || nc < 0 || nr >= active_side || nc >= active_side) continue;
      if (blocked_cell[nr][nc] || seen_cell[nr][nc]) continue;
      seen_cell[nr][nc] = 1'b1;
      mate = partner_of[nr][nc];
      if (mate < 0 || grow_path(mate / SIDE_MAX, mate % SIDE_MAX)) begin
        partner_of[nr][nc] = r * SIDE_MAX + c;
        partner_of[r][c] = nr * SIDE_MAX + nc;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Largest domino count on the free cells; clears the blocked map afterwards.
  function automatic logic [CNT_W-1:0] count_dominoes();
    int total;
    total = 0;
    active_side = (shadow_side > SIDE_MAX) ? SIDE_MAX : shadow_side;
    foreach (partner_of[r, c]) partner_of[r][c] = -1;
    for (int r = 0; r < active_side; r++) begin
      for (int c = 0; c < active_side; c++) begin
        if (((r + c) % 2) != 0 || blocked_cell[r][c] || partner_of[r][c] >= 0) continue;
        foreach (seen_cell[a, b]) seen_cell[a][b] = 1'b0;
        if (grow_path(r, c)) total++;
      end
    end
    foreach (blocked_cell[r, c]) blocked_cell[r][c] = 1'b0;
    if (total > CNT_MAX) total = CNT_MAX;
    return total[CNT_W-1:0];
  endfunction

  // Hold until no count is outstanding and the block has dropped busy, then write the side.
  task automatic write_side(input logic [5:0] side);
    @(negedge clk);
    start = 1'b0;
    while (pending_counts.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = side;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 6'($urandom_range(0, 63));
    shadow_side = side;
  endtask

  // Send one beat after a random gap; predict on acceptance.
  task automatic send_beat(input logic func, input logic [5:0] r, input logic [5:0] c,
                           input int typed_cnt);
    int gap;
    int eff;
    logic [CNT_W-1:0] predicted;
    gap = $urandom_range(0, 17);
    @(negedge clk);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_func = func;
    in_row = r;
    in_col = c;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent_beats++;
    if (func == FUNC_SOLVE) begin
      predicted = count_dominoes();
      pending_counts = {pending_counts,
                        ((typed_cnt == NO_EXPECT) ? predicted : typed_cnt[CNT_W-1:0])};
    end else begin
      eff = (shadow_side > SIDE_MAX) ? SIDE_MAX : shadow_side;
      if (r >= 1 && c >= 1 && r <= eff && c <= eff) begin
        blocked_cell[r - 1][c - 1] = 1'b1;
      end
    end
  endtask

  // Check every count beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected count beat: got %0d", out_pair_count);
      end else begin
        if (out_pair_count !== pending_counts[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pair_count mismatch: expected %0d got %0d",
                     pending_counts[0], out_pair_count);
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  stim_row_t stim_table[$];

  task automatic add_cfg(input logic [5:0] side);
    stim_row_t e;
    e = '{ROW_CFG, FUNC_BLOCK, 6'd0, 6'd0, side, NO_EXPECT};
    stim_table = {stim_table, e};
  endtask

  task automatic add_beat(input logic func, input logic [5:0] r, input logic [5:0] c,
                          input int cnt);
    stim_row_t e;
    e = '{ROW_ITEM, func, r, c, 6'd0, cnt};
    stim_table = {stim_table, e};
  endtask

  initial begin
    int side, loads, target;
    logic [5:0] r, c;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_BLOCK;
    in_row = '0;
    in_col = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    sent_beats = 0;
    shadow_side = 6'd32;
    foreach (blocked_cell[a, b]) blocked_cell[a][b] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: empty full grid after reset, side extremes, ignored cells,
    // cleared map after a solve, side shrunk after loading.
    add_beat(FUNC_SOLVE, 6'd0, 6'd0, 512);
    add_cfg(6'd1);
    add_beat(FUNC_SOLVE, 6'd0, 6'd0, 0);
    add_cfg(6'd0);
    add_beat(FUNC_BLOCK, 6'd1, 6'd1, NO_EXPECT);
    add_beat(FUNC_SOLVE, 6'd63, 6'd63, 0);
    add_cfg(6'd63);
    add_beat(FUNC_SOLVE, 6'd0, 6'd0, 512);
    add_cfg(6'd2);
    add_beat(FUNC_BLOCK, 6'd1, 6'd1, NO_EXPECT);
    add_beat(FUNC_BLOCK, 6'd0, 6'd1, NO_EXPECT);
    add_beat(FUNC_BLOCK, 6'd1, 6'd0, NO_EXPECT);
    add_beat(FUNC_BLOCK, 6'd63, 6'd63, NO_EXPECT);
    add_beat(FUNC_BLOCK, 6'd3, 6'd1, NO_EXPECT);
    add_beat(FUNC_SOLVE, 6'd0, 6'd0, 1);
    add_beat(FUNC_SOLVE, 6'd0, 6'd0, 2);
    add_cfg(6'd4);
    add_beat(FUNC_BLOCK, 6'd4, 6'd4, NO_EXPECT);
    add_beat(FUNC_BLOCK, 6'd1, 6'd2, NO_EXPECT);
    add_cfg(6'd2);
    add_beat(FUNC_SOLVE, 6'd0, 6'd0, NO_EXPECT);
    add_cfg(6'd32);
    add_beat(FUNC_BLOCK, 6'd32, 6'd32, NO_EXPECT);
    add_beat(FUNC_BLOCK, 6'd1, 6'd1, NO_EXPECT);
    add_beat(FUNC_SOLVE, 6'd0, 6'd0, NO_EXPECT);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) write_side(stim_table[i].side);
      else send_beat(stim_table[i].func, stim_table[i].row, stim_table[i].col,
                     stim_table[i].expect_cnt);
    end

    // Random phases: pick a side, load blocked cells, solve. Most sides stay small
    // so solves are quick; a few phases use the full grid or out-of-range sides.
    target = 700;
    while (sent_beats < target) begin
      case ($urandom_range(0, 9))
        0: side = $urandom_range(32, 63);
        1: side = $urandom_range(0, 1);
        default: side = $urandom_range(2, 8);
      endcase
      if ($urandom_range(0, 9) < 8) write_side(side[5:0]);
      side = (shadow_side > SIDE_MAX) ? SIDE_MAX : shadow_side;
      loads = $urandom_range(0, (side < 2) ? 3 : ((3 * side > 40) ? 40 : 3 * side));
      for (int k = 0; k < loads; k++) begin
        if ($urandom_range(0, 9) == 0 || side == 0) begin
          r = 6'($urandom_range(0, 63));
          c = 6'($urandom_range(0, 63));
        end else begin
          r = 6'($urandom_range(1, side));
          c = 6'($urandom_range(1, side));
        end
        send_beat(FUNC_BLOCK, r, c, NO_EXPECT);
        // Occasionally shrink or grow the grid in the middle of loading.
        if ($urandom_range(0, 39) == 0) write_side(6'($urandom_range(0, 63)));
      end
      send_beat(FUNC_SOLVE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                NO_EXPECT);
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    // Let the clear sweep after the last solve run out.
    repeat (2000) @(negedge clk);
    if (pending_counts.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
